// File: src/kwm_pkg.sv
// ----------------------------------------------------------------------------
// K-way sorted merge package
// Shared sizes, payload words, internal operation words and codes.
// ----------------------------------------------------------------------------
package kwm_pkg;

  // Number of sorted lists and the capacity of each one.
  localparam int LISTS = 8;
  localparam int DEPTH = 64;

  localparam int LIST_W   = $clog2(LISTS);
  localparam int PTR_W    = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int MEM_WORDS = LISTS * DEPTH;
  localparam int ADDR_W   = $clog2(MEM_WORDS);
  localparam int TOT_W    = $clog2(MEM_WORDS + 1);
  localparam int LEAVES   = 1 << LIST_W;

  // Operation queue between front and back; a power of two so pointers wrap.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_APPENDED = 2'd0,
    ST_POPPED   = 2'd1,
    ST_DROPPED  = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_APPEND,
    OP_REJECT,
    OP_POP
  } op_kind_t;

  typedef enum logic {
    BK_IDLE,
    BK_REFILL
  } back_state_t;

  typedef struct packed {
    logic               command;
    logic [2:0]         list_id;
    logic signed [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] value_out;
    status_t            status;
    logic [9:0]         remaining;
  } rsp_t;

  typedef struct packed {
    op_kind_t           kind;
    logic [LIST_W-1:0]  idx;
    logic signed [31:0] value;
  } op_t;

endpackage

// File: src/kwm_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module kwm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/kwm_front.sv
// ----------------------------------------------------------------------------
// K-way merge front end
// Accepts command words and classifies them into append, reject or pop.
// ----------------------------------------------------------------------------
module kwm_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  kwm_pkg::cmd_t cmd,
  output logic          op_valid,
  input  logic          op_ready,
  output kwm_pkg::op_t  op
);

  logic         fr_valid;
  kwm_pkg::op_t fr_op;
  kwm_pkg::op_t op_next;

  // A list number past the last list can never be stored, so it is turned
  // into a reject here and the back end never indexes with it.
  always_comb begin
    op_next.idx   = kwm_pkg::LIST_W'(cmd.list_id);
    op_next.value = cmd.value;
    if (cmd.command) begin
      op_next.kind = kwm_pkg::OP_POP;
    end else if (32'(cmd.list_id) < kwm_pkg::LISTS) begin
      op_next.kind = kwm_pkg::OP_APPEND;
    end else begin
      op_next.kind = kwm_pkg::OP_REJECT;
    end
  end

  assign cmd_ready = !fr_valid || op_ready;
  assign op_valid  = fr_valid;
  assign op        = fr_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else if (cmd_ready) begin
      fr_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      fr_op <= op_next;
    end
  end

endmodule

// File: src/kwm_queue.sv
// ----------------------------------------------------------------------------
// K-way merge operation queue
// Short FIFO of classified operations between the front and back ends.
// ----------------------------------------------------------------------------
module kwm_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_ready,
  input  kwm_pkg::op_t push_op,
  output logic         pop_valid,
  input  logic         pop_ready,
  output kwm_pkg::op_t pop_op
);

  kwm_pkg::op_t                slots [kwm_pkg::QUEUE_DEPTH];
  logic [kwm_pkg::QPTR_W-1:0] wr_ptr;
  logic [kwm_pkg::QPTR_W-1:0] rd_ptr;
  logic [kwm_pkg::QCNT_W-1:0] fill;
  logic                        push;
  logic                        pop;

  assign push_ready = fill != kwm_pkg::QCNT_W'(kwm_pkg::QUEUE_DEPTH);
  assign pop_valid  = fill != '0;
  assign pop_op     = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

endmodule

// File: src/kwm_back.sv
// ----------------------------------------------------------------------------
// K-way merge back end
// Holds the lists, picks the smallest cached head and refills it from memory.
// ----------------------------------------------------------------------------
module kwm_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_take,
  input  kwm_pkg::op_t  q_op,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output kwm_pkg::rsp_t rsp
);

  localparam int NODES = 2 * kwm_pkg::LEAVES;

  kwm_pkg::back_state_t        state;
  kwm_pkg::back_state_t        state_next;

  logic [kwm_pkg::PTR_W-1:0]   rp   [kwm_pkg::LISTS];
  logic [kwm_pkg::CNT_W-1:0]   cnt  [kwm_pkg::LISTS];
  logic signed [31:0]          head [kwm_pkg::LISTS];
  logic [kwm_pkg::TOT_W-1:0]   total;
  logic [kwm_pkg::LIST_W-1:0]  refill_idx;
  logic                        refill_live;
  kwm_pkg::rsp_t               rsp_word;
  kwm_pkg::rsp_t               rsp_next;

  // Minimum tree over the cached heads, heap numbered; node 1 is the root.
  logic                        nv   [1:NODES-1];
  logic signed [31:0]          nval [1:NODES-1];
  logic [kwm_pkg::LIST_W-1:0]  nidx [1:NODES-1];

  logic [kwm_pkg::LIST_W-1:0]  cur;
  logic [kwm_pkg::PTR_W-1:0]   cur_rp;
  logic [kwm_pkg::CNT_W-1:0]   cur_cnt;
  logic [kwm_pkg::CNT_W:0]     tail_sum;
  logic [kwm_pkg::PTR_W-1:0]   tail_slot;
  logic [kwm_pkg::PTR_W-1:0]   rp_inc;
  logic                        full;
  logic                        do_append;
  logic                        do_pop;
  logic                        mem_we;
  logic                        mem_re;
  logic [kwm_pkg::ADDR_W-1:0]  mem_waddr;
  logic [kwm_pkg::ADDR_W-1:0]  mem_raddr;
  logic [31:0]                 mem_rdata;

  genvar gi;
  generate
    for (gi = 0; gi < kwm_pkg::LEAVES; gi++) begin : g_leaf
      if (gi < kwm_pkg::LISTS) begin : g_used
        assign nv[kwm_pkg::LEAVES + gi]   = cnt[gi] != '0;
        assign nval[kwm_pkg::LEAVES + gi] = head[gi];
      end else begin : g_pad
        assign nv[kwm_pkg::LEAVES + gi]   = 1'b0;
        assign nval[kwm_pkg::LEAVES + gi] = '0;
      end
      assign nidx[kwm_pkg::LEAVES + gi] = kwm_pkg::LIST_W'(gi);
    end
    // The right child wins only when strictly smaller, so ties go to the
    // lower list number.
    for (gi = 1; gi < kwm_pkg::LEAVES; gi++) begin : g_node
      logic pick_r;
      assign pick_r = nv[2*gi+1] && (!nv[2*gi] || (nval[2*gi+1] < nval[2*gi]));
      assign nv[gi]   = nv[2*gi] || nv[2*gi+1];
      assign nval[gi] = pick_r ? nval[2*gi+1] : nval[2*gi];
      assign nidx[gi] = pick_r ? nidx[2*gi+1] : nidx[2*gi];
    end
  endgenerate

  // One list is touched per operation: the appended one or the popped one.
  always_comb begin
    cur       = (q_op.kind == kwm_pkg::OP_POP) ? nidx[1] : q_op.idx;
    cur_rp    = rp[cur];
    cur_cnt   = cnt[cur];
    full      = cur_cnt == kwm_pkg::CNT_W'(kwm_pkg::DEPTH);
    tail_sum  = (kwm_pkg::CNT_W+1)'(cur_rp) + (kwm_pkg::CNT_W+1)'(cur_cnt);
    tail_slot = (tail_sum >= (kwm_pkg::CNT_W+1)'(kwm_pkg::DEPTH))
              ? kwm_pkg::PTR_W'(tail_sum - (kwm_pkg::CNT_W+1)'(kwm_pkg::DEPTH))
              : kwm_pkg::PTR_W'(tail_sum);
    rp_inc    = (cur_rp == kwm_pkg::PTR_W'(kwm_pkg::DEPTH - 1)) ? '0 : cur_rp + 1'b1;
    mem_waddr = kwm_pkg::ADDR_W'(cur * kwm_pkg::DEPTH) + kwm_pkg::ADDR_W'(tail_slot);
    mem_raddr = kwm_pkg::ADDR_W'(cur * kwm_pkg::DEPTH) + kwm_pkg::ADDR_W'(rp_inc);
  end

  always_comb begin
    state_next         = state;
    q_take             = 1'b0;
    do_append          = 1'b0;
    do_pop             = 1'b0;
    rsp_next.value_out = '0;
    rsp_next.status    = kwm_pkg::ST_DROPPED;
    rsp_next.remaining = 10'(total);
    unique case (state)
      kwm_pkg::BK_IDLE: begin
        q_take = q_valid && (!rsp_valid || rsp_ready);
        if (q_take) begin
          case (q_op.kind)
            kwm_pkg::OP_APPEND: begin
              if (!full) begin
                do_append          = 1'b1;
                rsp_next.status    = kwm_pkg::ST_APPENDED;
                rsp_next.remaining = 10'(total + 1'b1);
              end
            end
            kwm_pkg::OP_POP: begin
              if (nv[1]) begin
                do_pop             = 1'b1;
                state_next         = kwm_pkg::BK_REFILL;
                rsp_next.value_out = nval[1];
                rsp_next.status    = kwm_pkg::ST_POPPED;
                rsp_next.remaining = 10'(total - 1'b1);
              end else begin
                rsp_next.status = kwm_pkg::ST_EMPTY;
              end
            end
            default: begin
              rsp_next.status = kwm_pkg::ST_DROPPED;
            end
          endcase
        end
      end
      kwm_pkg::BK_REFILL: begin
        state_next = kwm_pkg::BK_IDLE;
      end
      default: begin
        state_next = kwm_pkg::BK_IDLE;
      end
    endcase
  end

  assign mem_we = do_append;
  assign mem_re = do_pop;

  kwm_ram #(
    .WIDTH (32),
    .DEPTH (kwm_pkg::MEM_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (q_op.value),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kwm_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < kwm_pkg::LISTS; i++) begin
        rp[i]  <= '0;
        cnt[i] <= '0;
      end
      total     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (do_append) begin
        cnt[cur] <= cur_cnt + 1'b1;
        total    <= total + 1'b1;
      end
      if (do_pop) begin
        rp[cur]  <= rp_inc;
        cnt[cur] <= cur_cnt - 1'b1;
        total    <= total - 1'b1;
      end
      if (q_take) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Heads are only meaningful while their list is non-empty.
  always_ff @(posedge clk) begin
    if (do_append && (cur_cnt == '0)) begin
      head[cur] <= q_op.value;
    end
    if (state == kwm_pkg::BK_REFILL && refill_live) begin
      head[refill_idx] <= mem_rdata;
    end
    if (do_pop) begin
      refill_idx  <= cur;
      refill_live <= cur_cnt != kwm_pkg::CNT_W'(1);
    end
    if (q_take) begin
      rsp_word <= rsp_next;
    end
  end

  assign rsp = rsp_word;

endmodule

// File: src/k_way_sorted_merge_top.sv
// ----------------------------------------------------------------------------
// K-way sorted merge, top level
// Keeps up to LISTS sorted lists and pops their merged minimum.
// ----------------------------------------------------------------------------
//
//   channel | dir | handshake             | word
//   --------+-----+-----------------------+-----------------------------------
//   cmd     | in  | cmd_valid / cmd_ready | command, list_id, value
//   rsp     | out | rsp_valid / rsp_ready | value_out, status, remaining
//
// A word is handled by the back end in BK_IDLE; a pop that finds a value also
// passes BK_REFILL to load that list's next head from the registered memory read.
// Reset is synchronous and clears list counts and pointers; memory and cached
// heads are only read while they hold valid entries.
// A stalled rsp channel holds the back end; the front stage and the two-word
// queue then take three more command words before cmd_ready drops.
//
module k_way_sorted_merge_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  kwm_pkg::cmd_t cmd,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output kwm_pkg::rsp_t rsp
);

  // Front stage to queue.
  logic         fq_valid;
  logic         fq_ready;
  kwm_pkg::op_t fq_op;

  // Queue to back end.
  logic         q_valid;
  logic         q_take;
  kwm_pkg::op_t q_op;

  // The front end classifies each command word; a list number past the last
  // list becomes a reject that the back end answers as a dropped word.
  kwm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .op_valid  (fq_valid),
    .op_ready  (fq_ready),
    .op        (fq_op)
  );

  // The queue lets the front keep accepting while a pop refill or a stalled
  // response holds the back end.
  kwm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_op    (fq_op),
    .pop_valid  (q_valid),
    .pop_ready  (q_take),
    .pop_op     (q_op)
  );

  // The back end owns the list state, the element memory and the response
  // register, and answers every operation with exactly one response word.
  kwm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_take    (q_take),
    .q_op      (q_op),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

`ifndef ASSERT_OFF
  // Only a popped word carries a value.
  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != kwm_pkg::ST_POPPED) |-> rsp.value_out == '0)
    else $error("non-pop response carries a value");

  // All lists empty means nothing is held.
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == kwm_pkg::ST_EMPTY) |-> rsp.remaining == '0)
    else $error("empty response with elements remaining");

  // The back end only consumes an operation the queue actually holds.
  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    q_take |-> q_valid)
    else $error("back end took from an empty queue");
`endif

endmodule

// File: bench/kwm_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// K-way sorted merge bench package
// Command codes shared by the stimulus side and the checker.
// ----------------------------------------------------------------------------
package kwm_tb_pkg;

  // Values of the one-bit command field of a cmd word.
  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_POP    = 1'b1;

endpackage

// File: bench/kwm_merge_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// K-way sorted merge checker
// Watches both channels, keeps its own copy of the lists, works out the rsp
// word owed for every accepted cmd word and compares each rsp word with it.
// ----------------------------------------------------------------------------
module kwm_merge_checker
  import kwm_pkg::*;
  import kwm_tb_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  cmd_valid,
  input  logic  cmd_ready,
  input  cmd_t  cmd,
  input  logic  rsp_valid,
  input  logic  rsp_ready,
  input  rsp_t  rsp,
  output int    fail_count,
  output int    pending,
  output int    held
);

  logic signed [31:0] elem_mem [LISTS*DEPTH];
  logic signed [31:0] head_q   [LISTS];
  int                 rd_ptr   [LISTS];
  int                 list_fill[LISTS];
  int                 held_total;
  int                 errors;
  rsp_t               owed_rsps[$];

  initial begin
    errors     = 0;
    fail_count = 0;
    pending    = 0;
    held       = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (errors < 100) begin
      $display("[%0t] rsp %s: got %h, want %h", $realtime, what, got, want);
    end
    errors++;
  endtask

  // Applies one cmd word to the local lists and returns the rsp word it owes.
  function automatic rsp_t merge_step(input cmd_t w);
    rsp_t r;
    int   best;
    int   slot;
    r    = '0;
    best = -1;
    if (w.command == CMD_APPEND) begin
      if (int'(w.list_id) >= LISTS || list_fill[w.list_id] >= DEPTH) begin
        r.status = ST_DROPPED;
      end else begin
        slot = (rd_ptr[w.list_id] + list_fill[w.list_id]) % DEPTH;
        elem_mem[w.list_id*DEPTH + slot] = w.value;
        if (list_fill[w.list_id] == 0) head_q[w.list_id] = w.value;
        list_fill[w.list_id]++;
        held_total++;
        r.status = ST_APPENDED;
      end
    end else begin
      // Strictly smaller replaces, so the lowest list wins a tie.
      for (int i = 0; i < LISTS; i++) begin
        if (list_fill[i] != 0 && (best < 0 || head_q[i] < head_q[best])) best = i;
      end
      if (best < 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.value_out  = head_q[best];
        r.status     = ST_POPPED;
        rd_ptr[best] = (rd_ptr[best] + 1) % DEPTH;
        list_fill[best]--;
        held_total--;
        if (list_fill[best] != 0) head_q[best] = elem_mem[best*DEPTH + rd_ptr[best]];
      end
    end
    r.remaining = 10'(held_total);
    return r;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      foreach (list_fill[i]) begin
        list_fill[i] = 0;
        rd_ptr[i]    = 0;
      end
      held_total = 0;
      owed_rsps.delete();
    end else begin
      // The new word goes in first so a same-edge rsp still meets the oldest.
      if (cmd_valid && cmd_ready) owed_rsps.push_back(merge_step(cmd));
      if (rsp_valid && rsp_ready) begin
        if (owed_rsps.size() == 0) begin
          report_mismatch("word with none owed", rsp.value_out, 32'h0);
        end else begin
          want = owed_rsps.pop_front();
          if (rsp.value_out !== want.value_out)
            report_mismatch("value_out", rsp.value_out, want.value_out);
          if (rsp.status !== want.status)
            report_mismatch("status", 32'(rsp.status), 32'(want.status));
          if (rsp.remaining !== want.remaining)
            report_mismatch("remaining", 32'(rsp.remaining), 32'(want.remaining));
        end
      end
    end
    pending    <= owed_rsps.size();
    held       <= held_total;
    fail_count <= errors;
  end

endmodule

// File: bench/k_way_sorted_merge_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// K-way sorted merge testbench
// Drives append and pop words into the merge block, mostly as sorted per-list
// runs with fills past capacity and full drains, under random sender gaps and
// receiver stalls, while a checker beside the block predicts every rsp word.
// ----------------------------------------------------------------------------
module k_way_sorted_merge_top_tb;
  import kwm_pkg::*;
  import kwm_tb_pkg::*;

  // Number of random cmd words after the directed part.
  localparam int RANDOM_ITEMS = 1200;
  // Cycles without any accepted word before the run is declared hung. The
  // longest legal quiet stretch is the long receiver hold below.
  localparam int QUIET_LIMIT  = 3000;
  // Length of the deliberate receiver hold-off, in cycles.
  localparam int HOLD_CYCLES  = 400;
  // Cycles to watch for stray rsp words once nothing is owed any more.
  localparam int SETTLE_CYCLES = 24;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  cmd_t cmd       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  int fail_count;
  int pending;
  int held;

  // Stimulus bookkeeping. list_tail is the last value appended to each list,
  // so new appends can keep every list in non-decreasing order.
  logic signed [31:0] list_tail[LISTS];
  int                 sent       = 0;
  int                 burst_left = 0;
  int                 quiet      = 0;
  // Each increment asks the receiver for one long hold-off.
  int                 hold_asks  = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  k_way_sorted_merge_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  kwm_merge_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp),
    .fail_count (fail_count),
    .pending    (pending),
    .held       (held)
  );

  // Offers one cmd word and returns at the edge where it is accepted. The
  // sender works in bursts; at the start of each burst it may drop valid
  // before offering the word. Valid is never lowered between words of one
  // burst, so a step never carries two assignments to it.
  task automatic send_word(input logic c, input logic [2:0] id,
                           input logic signed [31:0] v);
    cmd_t w;
    int   gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        cmd_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    w.command = c;
    w.list_id = id;
    w.value   = v;
    cmd       <= w;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    sent++;
  endtask

  // Stops offering and waits until every owed rsp word has come back.
  task automatic wait_drained();
    cmd_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Next value for a list: its tail plus a random step, saturating at the top
  // of the signed range so the list stays sorted.
  function automatic logic signed [31:0] grow_tail(input int id, input int unsigned step);
    longint t;
    t = longint'(list_tail[id]) + longint'($urandom_range(step, 0));
    if (t > 64'sd2147483647) t = 64'sd2147483647;
    list_tail[id] = 32'(t);
    return list_tail[id];
  endfunction

  // Picks fresh starting points for the lists once they are empty. Each list
  // takes one shared base half the time, which makes ties between lists common.
  function automatic void restart_tails();
    logic signed [31:0] base;
    base = $urandom;
    foreach (list_tail[i]) begin
      if ($urandom_range(0, 1) == 0) begin
        list_tail[i] = base;
      end else begin
        case ($urandom_range(0, 2))
          0:       list_tail[i] = 32'sh8000_0000 + $urandom_range(0, 1000);
          1:       list_tail[i] = $urandom;
          default: list_tail[i] = 32'sh7FFF_FFFF - $urandom_range(0, 5000);
        endcase
      end
    end
  endfunction

  // Receiver: changes its stall pattern every so often, and on request goes
  // quiet for a long stretch that it counts itself.
  initial begin : rsp_side
    int mode;
    int left;
    int tick;
    int hold_seen;
    mode      = 0;
    left      = 0;
    tick      = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(8, 120);
      end
      left--;
      tick++;
      case (mode)
        0:       rsp_ready <= 1'b1;
        1:       rsp_ready <= ($urandom_range(0, 1) == 1);
        2:       rsp_ready <= (tick % 4 == 0);
        default: rsp_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Watchdog: any accepted word on either channel clears the quiet count.
  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_ready) || (rsp_valid && rsp_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : stimulus
    int kind;
    int n;
    int id;
    int unsigned step;
    int next_hold;
    int holds_left;
    int stop_at;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part. A pop on an empty block, then both ends of the signed
    // range, alternating bit patterns, a tie inside one list and a tie across
    // lists, all list indices, and pops that must come out in merged
    // order with the lowest list taking each tie. Pops carry junk payloads,
    // which the block must ignore. A final pop finds everything empty again.
    send_word(CMD_POP, 3'd7, 32'sh7FFF_FFFF);
    send_word(CMD_APPEND, 3'd0, 32'sh8000_0000);
    send_word(CMD_APPEND, 3'd7, 32'sh7FFF_FFFF);
    send_word(CMD_APPEND, 3'd3, 32'sd0);
    send_word(CMD_APPEND, 3'd3, 32'sd0);
    send_word(CMD_APPEND, 3'd5, 32'sd0);
    send_word(CMD_APPEND, 3'd1, -32'sd1);
    send_word(CMD_APPEND, 3'd2, 32'sh5555_5555);
    send_word(CMD_APPEND, 3'd4, 32'shAAAA_AAAA);
    send_word(CMD_APPEND, 3'd6, 32'sd1);
    repeat (9) send_word(CMD_POP, 3'($urandom), $urandom);
    send_word(CMD_POP, 3'd0, 32'sh8000_0000);
    restart_tails();

    // Random part. It opens with one list filled past capacity so the
    // dropped case is always reached, then mixes sequence kinds: sorted
    // append/pop runs, more overfills, full drains behind a sender pause,
    // and pure noise that breaks the ordering of the lists.
    stop_at    = sent + RANDOM_ITEMS;
    next_hold  = sent + 300;
    holds_left = 2;
    kind       = 60;
    while (sent < stop_at) begin
      if (kind < 50) begin
        // A long receiver hold while the sender keeps offering words, so the
        // block fills up and has to stall its cmd channel.
        if (holds_left > 0 && sent >= next_hold) begin
          hold_asks <= hold_asks + 1;
          holds_left--;
          next_hold  = sent + 500;
          burst_left = 60;
        end
        n = $urandom_range(10, 40);
        case ($urandom_range(0, 3))
          0:       step = 0;
          1:       step = 3;
          2:       step = 1000;
          default: step = 32'h0100_0000;
        endcase
        repeat (n) begin
          if ($urandom_range(0, 9) < 6) begin
            id = $urandom_range(0, LISTS - 1);
            send_word(CMD_APPEND, 3'(id), grow_tail(id, step));
          end else begin
            send_word(CMD_POP, 3'($urandom), $urandom);
          end
        end
      end else if (kind < 65) begin
        // Overfill one list: at least one value must be dropped.
        id = $urandom_range(0, LISTS - 1);
        step = $urandom_range(0, 1) ? 2 : 32'h0001_0000;
        repeat (DEPTH + $urandom_range(1, 3)) send_word(CMD_APPEND, 3'(id), grow_tail(id, step));
      end else if (kind < 80) begin
        // Pause the sender until nothing is owed, then pop everything held
        // plus one or two more, which must report all lists empty.
        wait_drained();
        n = held + $urandom_range(1, 2);
        repeat (n) send_word(CMD_POP, 3'($urandom), $urandom);
        restart_tails();
      end else begin
        n = $urandom_range(2, 12);
        repeat (n) send_word(1'($urandom), 3'($urandom), $urandom);
      end
      kind = $urandom_range(0, 99);
    end

    // Let every owed word come back, then watch a little longer for strays.
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
